FILE: src/sss_pkg.sv
// shared types and constants for the sorted set statistics block
package sss_pkg;

  localparam int SAMPLE_W = 32;
  localparam int OUT_W    = 32;
  localparam int CFG_W    = 32;
  localparam int ADDR_W   = 3;

  // quartile selector codes; zero falls back to the median
  localparam logic [1:0] QSEL_LOWER  = 2'd1;
  localparam logic [1:0] QSEL_MEDIAN = 2'd2;
  localparam logic [1:0] QSEL_UPPER  = 2'd3;

  // register index, taken from the word address bit
  localparam logic REG_QSEL = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] minimum;
    logic signed [OUT_W-1:0] maximum;
    logic signed [OUT_W-1:0] mean_value;
    logic signed [OUT_W-1:0] quartile_value;
    logic                    empty_flag;
    logic                    overflow_flag;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: src/sss_cell.sv
// one cell of the sorted insertion chain
module sss_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                                clk,
  input  sss_pkg::cell_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                    count,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] left_val,
  input  logic                                left_grt,
  input  logic signed [sss_pkg::SAMPLE_W-1:0] right_val,
  output logic signed [sss_pkg::SAMPLE_W-1:0] val,
  output logic                                grt
);
  import sss_pkg::*;

  logic signed [SAMPLE_W-1:0] val_r;
  logic signed [SAMPLE_W-1:0] val_nxt;
  logic                       occ;

  // an empty cell behaves as plus infinity so the new item lands at the fill edge
  assign occ = CNT_W'(IDX) < count;
  assign grt = !occ || (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      val_nxt = right_val;
    end else if (ctrl.insert && grt) begin
      val_nxt = left_grt ? left_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: src/sss_div.sv
// restoring divider for the mean, one quotient bit a cycle, truncating toward zero
module sss_div #(
  parameter int SUM_W = 38,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic signed [SUM_W-1:0] quot,
  output logic                    done
);
  import sss_pkg::*;

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  logic              run_r, done_r, neg_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  acc_r;
  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    trial;
  logic              take;

  assign trial = {rem_r[CNT_W-1:0], acc_r[SUM_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (run_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend[SUM_W-1] ? -dividend : dividend;
      neg_r <= dividend[SUM_W-1];
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      acc_r <= {acc_r[SUM_W-2:0], take};
      rem_r <= take ? (trial - {1'b0, dvs_r}) : trial;
    end
  end

  assign quot = neg_r ? -$signed(acc_r) : $signed(acc_r);
  assign done = done_r;

endmodule

FILE: src/sorted_set_statistics.sv
// sorted set statistics: insertion chain, drain collector and mean divider
//
//  channel   ports                               handshake
//  input     start, busy, in_data                taken when start high and busy low
//  result    out_valid, out_data                 one cycle strobe, no back pressure
//  config    psel, penable, pwrite, paddr, ...   apb style, pready always high
//
// ordinary items: one per cycle, each inserted into the cell chain, or dropped with
// the overflow mark set once the chain is full. an item marked last: the set drains
// through cell 0 while the divider runs in parallel; busy holds until both end.
// the result strobe comes in the first cycle with busy low again.
// reset clears count, sum, overflow mark and selector (median); cells need no clear.
// the result strobe lasts one cycle and cannot be stalled.
module sorted_set_statistics #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  sss_pkg::in_item_t           in_data,
  output logic                        out_valid,
  output sss_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sss_pkg::ADDR_W-1:0]  paddr,
  input  logic [sss_pkg::CFG_W-1:0]   pwdata,
  output logic [sss_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);
  import sss_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]             state_r;
  logic [CNT_W-1:0]       count_r, k_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                   drop_r;
  logic [1:0]             qsel_r;
  logic                   out_valid_r;
  out_item_t              out_r;
  logic signed [SAMPLE_W-1:0] min_r, max_r, qa_r, qb_r;

  logic       accept, full, cfg_wr;
  cell_ctrl_t ctrl;

  logic signed [SAMPLE_W-1:0] cval [MAX_SAMPLES];
  logic                       cgrt [MAX_SAMPLES];
  logic signed [SAMPLE_W-1:0] head;

  logic signed [SUM_W-1:0] quot;
  logic                    div_done, div_start;

  logic [CNT_W-1:0] half, lo, len, mid, idx_a, idx_b, n_last;
  logic             empty_sel;
  logic [SAMPLE_W:0] qsum;

  assign accept = start && !busy;
  assign full   = count_r == CNT_W'(MAX_SAMPLES);
  assign busy   = state_r != ST_LOAD;
  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = state_r == ST_DRAIN;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_QSEL);
  assign prdata = (paddr[2] == REG_QSEL) ? {{(CFG_W-2){1'b0}}, qsel_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsel_r <= QSEL_MEDIAN;
    end else if (cfg_wr) begin
      qsel_r <= pwdata[1:0];
    end
  end

  // insertion chain, drained toward cell 0
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] lval, rval;
    logic                       lgrt;
    if (i == 0) begin : g_first
      assign lval = '0;
      assign lgrt = 1'b0;
    end else begin : g_mid
      assign lval = cval[i-1];
      assign lgrt = cgrt[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_end
      assign rval = cval[i];
    end else begin : g_inner
      assign rval = cval[i+1];
    end
    sss_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .sample    (in_data.sample),
      .left_val  (lval),
      .left_grt  (lgrt),
      .right_val (rval),
      .val       (cval[i]),
      .grt       (cgrt[i])
    );
  end

  assign head = cval[0];

  // positions of the quartile pair in the sorted set
  always_comb begin
    half = count_r >> 1;
    priority if (qsel_r == QSEL_LOWER) begin
      lo  = '0;
      len = half;
    end else if (qsel_r == QSEL_UPPER) begin
      lo  = half + CNT_W'(count_r[0]);
      len = count_r - lo;
    end else begin
      lo  = '0;
      len = count_r;
    end
    mid       = lo + (len >> 1);
    idx_b     = mid;
    idx_a     = len[0] ? mid : mid - 1'b1;
    empty_sel = (count_r == '0) || (len == '0);
    n_last    = count_r - 1'b1;
  end

  assign div_start = (state_r == ST_DRAIN) && (k_r == '0);

  sss_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .quot     (quot),
    .done     (div_done)
  );

  // odd subsets capture the same element twice, so the halved sum serves both cases
  assign qsum = {qa_r[SAMPLE_W-1], qa_r} + {qb_r[SAMPLE_W-1], qb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (full) begin
              drop_r <= 1'b1;
            end else begin
              count_r <= count_r + 1'b1;
              sum_r   <= sum_r + {{(SUM_W-SAMPLE_W){in_data.sample[SAMPLE_W-1]}},
                                  in_data.sample};
            end
            if (in_data.last) begin
              state_r <= ST_DRAIN;
              k_r     <= '0;
            end
          end
        end
        ST_DRAIN: begin
          k_r <= k_r + 1'b1;
          if (k_r == n_last || count_r == '0) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            count_r     <= '0;
            sum_r       <= '0;
            drop_r      <= 1'b0;
            state_r     <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // collector at the head of the chain
  always_ff @(posedge clk) begin
    if (state_r == ST_DRAIN) begin
      if (k_r == '0) begin
        min_r <= head;
      end
      if (k_r == n_last) begin
        max_r <= head;
      end
      if (k_r == idx_a) begin
        qa_r <= head;
      end
      if (k_r == idx_b) begin
        qb_r <= head;
      end
    end
    if (state_r == ST_WAIT && div_done) begin
      if (count_r == '0) begin
        out_r.minimum    <= '0;
        out_r.maximum    <= '0;
        out_r.mean_value <= '0;
      end else begin
        out_r.minimum    <= min_r[OUT_W-1:0];
        out_r.maximum    <= max_r[OUT_W-1:0];
        out_r.mean_value <= quot[OUT_W-1:0];
      end
      out_r.quartile_value <= empty_sel ? '0 : qsum[OUT_W:1];
      out_r.empty_flag     <= empty_sel;
      out_r.overflow_flag  <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_SAMPLES))
    else $error("fill count beyond capacity");

  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_WAIT) && $past(div_done))
    else $error("result issued before the divider finished");

  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r == '0) && !drop_r && (state_r == ST_LOAD))
    else $error("set state not cleared with the result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held more than one cycle");

endmodule
